// ===== design/spa_pkg.sv =====
// Package for the sparse polynomial adder: request and result structs,
// operation codes and the default store capacity. No dependencies.
package spa_pkg;

	localparam int SPA_MAX_TERMS = 32;
	localparam int COEF_W = 32;
	localparam int EXP_W = 16;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_MERGE = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic signed [COEF_W-1:0] coefficient;
		logic [EXP_W-1:0] exponent;
	} spa_req_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient_out;
		logic [EXP_W-1:0] exponent_out;
		logic term_valid;
		logic is_last;
		logic overflow;
	} spa_res_t;

endpackage

// ===== design/sparse_polynomial_adder_core.sv =====
// Top level of the sparse polynomial adder: command handshake, control sequencer
// and saturating adder around one term store. Uses spa_pkg and spa_ram.
//
// A load request is handled without leaving idle. A merge request on a drained
// store emits B directly; otherwise the compare state releases each stored A term
// with a larger exponent, then emits B, the saturated sum (dropped when zero) or,
// once the store runs out, B from the tail state. A finish request on a drained
// store emits an end marker; otherwise it releases each remaining term in turn.
// Each result appears for one cycle with strobe high and cannot be held off by the
// receiver.
module sparse_polynomial_adder_core #(
	parameter int MAX_TERMS = spa_pkg::SPA_MAX_TERMS
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input spa_pkg::spa_req_t req,
	output logic strobe,
	output spa_pkg::spa_res_t res
);
	import spa_pkg::*;

	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int DW = COEF_W + EXP_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MCMP = 2'd1;
	localparam logic [1:0] S_MTAIL = 2'd2;
	localparam logic [1:0] S_FCMP = 2'd3;

	logic [1:0] state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] rptr_q, rptr_d;
	logic ovf_q, ovf_d;
	spa_req_t b_q, b_d;
	logic strobe_q, strobe_d;
	spa_res_t res_q, res_d;

	logic accept;
	logic we;
	logic [DW-1:0] rdata;
	logic signed [COEF_W-1:0] a_coef;
	logic [EXP_W-1:0] a_exp;
	logic signed [COEF_W:0] sum;
	logic signed [COEF_W-1:0] sat;
	logic [CW-1:0] rptr_inc;

	spa_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_TERMS)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(count_q[AW-1:0]),
		.wdata({req.coefficient, req.exponent}),
		.raddr(rptr_d[AW-1:0]),
		.rdata(rdata)
	);

	assign accept = start && !busy;
	assign we = accept && (req.operation == OP_LOAD) && (count_q < CW'(MAX_TERMS));
	assign a_coef = rdata[DW-1:EXP_W];
	assign a_exp = rdata[EXP_W-1:0];
	assign rptr_inc = rptr_q + CW'(1);
	assign sum = {a_coef[COEF_W-1], a_coef} + {b_q.coefficient[COEF_W-1], b_q.coefficient};

	always_comb begin
		if (sum[COEF_W] != sum[COEF_W-1]) begin
			sat = sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
		end else begin
			sat = sum[COEF_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		rptr_d = rptr_q;
		ovf_d = ovf_q;
		b_d = b_q;
		strobe_d = 1'b0;
		res_d = res_q;
		res_d.overflow = ovf_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					b_d = req;
					case (req.operation)
						OP_LOAD: begin
							if (count_q < CW'(MAX_TERMS)) begin
								count_d = count_q + CW'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
						OP_MERGE: begin
							if (rptr_q < count_q) begin
								state_d = S_MCMP;
							end else begin
								strobe_d = 1'b1;
								res_d.coefficient_out = req.coefficient;
								res_d.exponent_out = req.exponent;
								res_d.term_valid = 1'b1;
								res_d.is_last = 1'b0;
							end
						end
						OP_FINISH: begin
							if (rptr_q < count_q) begin
								state_d = S_FCMP;
							end else begin
								strobe_d = 1'b1;
								res_d.coefficient_out = '0;
								res_d.exponent_out = '0;
								res_d.term_valid = 1'b0;
								res_d.is_last = 1'b1;
								count_d = '0;
								rptr_d = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_MCMP: begin
				res_d.term_valid = 1'b1;
				res_d.is_last = 1'b0;
				if (a_exp > b_q.exponent) begin
					strobe_d = 1'b1;
					res_d.coefficient_out = a_coef;
					res_d.exponent_out = a_exp;
					rptr_d = rptr_inc;
					if (rptr_inc >= count_q) begin
						state_d = S_MTAIL;
					end
				end else if (a_exp == b_q.exponent) begin
					strobe_d = (sat != '0);
					res_d.coefficient_out = sat;
					res_d.exponent_out = b_q.exponent;
					rptr_d = rptr_inc;
					state_d = S_IDLE;
				end else begin
					strobe_d = 1'b1;
					res_d.coefficient_out = b_q.coefficient;
					res_d.exponent_out = b_q.exponent;
					state_d = S_IDLE;
				end
			end
			S_MTAIL: begin
				strobe_d = 1'b1;
				res_d.coefficient_out = b_q.coefficient;
				res_d.exponent_out = b_q.exponent;
				res_d.term_valid = 1'b1;
				res_d.is_last = 1'b0;
				state_d = S_IDLE;
			end
			S_FCMP: begin
				strobe_d = 1'b1;
				res_d.coefficient_out = a_coef;
				res_d.exponent_out = a_exp;
				res_d.term_valid = 1'b1;
				res_d.is_last = (rptr_inc >= count_q);
				if (rptr_inc >= count_q) begin
					count_d = '0;
					rptr_d = '0;
					state_d = S_IDLE;
				end else begin
					rptr_d = rptr_inc;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rptr_q <= '0;
			ovf_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rptr_q <= rptr_d;
			ovf_q <= ovf_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		b_q <= b_d;
		res_q <= res_d;
	end

	assign busy = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign res = res_q;

`ifndef NO_ASSERTIONS
	a_rptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rptr_q <= count_q) else $error("read pointer passed the term count");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TERMS)) else $error("term count exceeds capacity");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && res_q.is_last |-> count_q == '0 && rptr_q == '0)
		else $error("store not emptied after the last result");
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(ovf_q)) else $error("overflow flag cleared without reset");
`endif

endmodule

// ===== design/spa_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module spa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
